[design/idel_pkg.sv]
// ----------------------------------------------------------------------------
// idel_pkg: shared types and constants of the indexed double-ended list
// Holds the list geometry, the request codes, the per-cell shift commands
// and the word conversion helpers used by the controller, cells and top.
// ----------------------------------------------------------------------------
package idel_pkg;

  // List geometry.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CMP_W      = (CNT_W > 5) ? CNT_W : 5;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Request codes carried on the op field.
  typedef enum logic [3:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_POP_BACK   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_READ       = 4'd4,
    OP_WRITE      = 4'd5,
    OP_INSERT     = 4'd6,
    OP_DELETE     = 4'd7,
    OP_WRITE_HEAD = 4'd8,
    OP_WRITE_TAIL = 4'd9
  } op_e;

  // What the list does with one accepted request.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_DELETE,
    ACT_WRITE,
    ACT_READ
  } act_e;

  // Command that one cell applies at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOWER,
    CELL_FROM_UPPER
  } cell_cmd_e;

  // Decoded request, handed from the controller to the top level.
  typedef struct packed {
    act_e act;
    logic ok;
    cnt_t at;
    cnt_t count;
  } plan_t;

  // Keep the low DATA_WIDTH bits of a 32-bit input word.
  function automatic word_t to_word(logic [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word and present its low 32 bits.
  function automatic logic [31:0] widen(word_t w);
    logic [63:0] e;
    e = 64'(signed'(w));
    return e[31:0];
  endfunction

endpackage

[design/indexed_double_ended_list.sv]
// ----------------------------------------------------------------------------
// indexed_double_ended_list: bounded ordered list of signed words
// A chain of cells holds the entries, head in cell zero, and shifts them
// by one place to open or close a gap for insert, delete, push and pop.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid_i / in_ready_o) carries op_i, position_i
//   and value_i. The result channel (out_valid_o / out_ready_i) returns
//   ok_o, data_out_o and count_o, exactly one result for each request.
//   A request is decoded, applied to the whole chain and its result
//   registered together, so the result appears in the cycle after the
//   request is taken. One request is taken per cycle while results are
//   taken, the rate being set by the cell chain shift and output register.
//   While a result waits, a new request is still taken in the cycle in
//   which the receiver takes that result; if the receiver stalls, the
//   result holds and in_ready_o drops until it is taken.
//   Reset empties the list and clears the result channel; entry contents
//   are not cleared and are never shown before they are written.
// ----------------------------------------------------------------------------
module indexed_double_ended_list
  import idel_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         op_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic signed [31:0] data_out_o,
  output logic [4:0]         count_o
);

  cnt_t        count_q, count_d;
  logic        out_valid_q, out_valid_d;
  logic        ok_q;
  logic [31:0] data_q, data_d;
  cnt_t        count_out_q;
  logic        in_fire;
  plan_t       plan;
  act_e        act;
  word_t       load_word;
  word_t       cell_word [CAPACITY];
  cell_cmd_e   cell_cmd  [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_word  = to_word(value_i);

  // Decode the request against the current length.
  idel_ctrl u_ctrl (
    .op_i       (op_i),
    .position_i (position_i),
    .count_i    (count_q),
    .plan_o     (plan)
  );

  assign act = in_fire ? plan.act : ACT_NONE;

  // Per-cell shift commands and the chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t lower_w, upper_w;

    always_comb begin
      cell_cmd[i] = CELL_HOLD;
      case (act)
        ACT_INSERT: begin
          if (cnt_t'(i) == plan.at) begin
            cell_cmd[i] = CELL_LOAD;
          end else if ((cnt_t'(i) > plan.at) && (cnt_t'(i) <= count_q)) begin
            cell_cmd[i] = CELL_FROM_LOWER;
          end
        end
        ACT_DELETE: begin
          if ((cnt_t'(i) >= plan.at) && (cnt_t'(i + 1) < count_q)) begin
            cell_cmd[i] = CELL_FROM_UPPER;
          end
        end
        ACT_WRITE: begin
          if (cnt_t'(i) == plan.at) begin
            cell_cmd[i] = CELL_LOAD;
          end
        end
        default: begin
          cell_cmd[i] = CELL_HOLD;
        end
      endcase
    end

    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_inner_lo
      assign lower_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_inner_hi
      assign upper_w = cell_word[i+1];
    end

    idel_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd[i]),
      .load_i  (load_word),
      .lower_i (lower_w),
      .upper_i (upper_w),
      .word_o  (cell_word[i])
    );
  end

  // Returned word: read, popped or deleted entry, zero otherwise.
  always_comb begin
    if ((act == ACT_READ) || (act == ACT_DELETE)) begin
      data_d = widen(cell_word[plan.at[IDX_W-1:0]]);
    end else begin
      data_d = '0;
    end
  end

  // Length and result valid.
  always_comb begin
    count_d     = in_fire ? plan.count : count_q;
    out_valid_d = in_fire ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded when a request is taken.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q        <= plan.ok;
      data_q      <= data_d;
      count_out_q <= plan.count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign data_out_o  = signed'(data_q);
  assign count_o     = 5'(count_out_q);

  // Length never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(CAPACITY))
    else $error("list length above capacity");

  // A successful insert grows the list by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && plan.ok && (plan.act == ACT_INSERT))
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the list by one");

  // A failed request leaves the length unchanged.
  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !plan.ok) |=> (count_q == $past(count_q)))
    else $error("failed request changed the list length");

  // A failed result carries a zero data word.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (data_out_o == '0))
    else $error("failed result with nonzero data");

  // The reported length matches the list length after the request.
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (count_out_q == count_q))
    else $error("reported length differs from list length");

endmodule

[design/idel_cell.sv]
// ----------------------------------------------------------------------------
// idel_cell: one storage cell of the list chain
// Holds one entry and each cycle either keeps it, loads the request word,
// or takes the entry of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module idel_cell
  import idel_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_e cmd_i,
  input  word_t     load_i,
  input  word_t     lower_i,
  input  word_t     upper_i,
  output word_t     word_o
);

  word_t word_q, word_d;

  // Select the next content of the cell.
  always_comb begin
    case (cmd_i)
      CELL_LOAD:       word_d = load_i;
      CELL_FROM_LOWER: word_d = lower_i;
      CELL_FROM_UPPER: word_d = upper_i;
      default:         word_d = word_q;
    endcase
  end

  // Entry storage needs no reset: entries past the length are never read.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

[design/idel_ctrl.sv]
// ----------------------------------------------------------------------------
// idel_ctrl: request decoder of the list
// Checks a request against the current length and turns it into an action,
// a target position and the new length.
// ----------------------------------------------------------------------------
module idel_ctrl
  import idel_pkg::*;
(
  input  logic [3:0] op_i,
  input  logic [4:0] position_i,
  input  cnt_t       count_i,
  output plan_t      plan_o
);

  logic [CMP_W-1:0] occ;
  logic [CMP_W-1:0] pos;
  logic             full;
  logic             empty;
  cnt_t             count_inc;
  cnt_t             count_dec;

  assign occ       = CMP_W'(count_i);
  assign pos       = CMP_W'(position_i);
  assign full      = (occ >= CMP_W'(CAPACITY));
  assign empty     = (count_i == '0);
  assign count_inc = count_i + 1'b1;
  assign count_dec = count_i - 1'b1;

  // Decode the request; a failed request leaves action and length alone.
  always_comb begin
    plan_o.act   = ACT_NONE;
    plan_o.ok    = 1'b0;
    plan_o.at    = '0;
    plan_o.count = count_i;
    case (op_i)
      OP_PUSH_BACK: begin
        if (!full) begin
          plan_o = '{act: ACT_INSERT, ok: 1'b1, at: count_i, count: count_inc};
        end
      end
      OP_PUSH_FRONT: begin
        if (!full) begin
          plan_o = '{act: ACT_INSERT, ok: 1'b1, at: '0, count: count_inc};
        end
      end
      OP_POP_BACK: begin
        if (!empty) begin
          plan_o = '{act: ACT_DELETE, ok: 1'b1, at: count_dec, count: count_dec};
        end
      end
      OP_POP_FRONT: begin
        if (!empty) begin
          plan_o = '{act: ACT_DELETE, ok: 1'b1, at: '0, count: count_dec};
        end
      end
      OP_READ: begin
        if (pos < occ) begin
          plan_o = '{act: ACT_READ, ok: 1'b1, at: CNT_W'(pos), count: count_i};
        end
      end
      OP_WRITE: begin
        if (pos < occ) begin
          plan_o = '{act: ACT_WRITE, ok: 1'b1, at: CNT_W'(pos), count: count_i};
        end
      end
      OP_INSERT: begin
        if (!full && (pos <= occ)) begin
          plan_o = '{act: ACT_INSERT, ok: 1'b1, at: CNT_W'(pos), count: count_inc};
        end
      end
      OP_DELETE: begin
        if (pos < occ) begin
          plan_o = '{act: ACT_DELETE, ok: 1'b1, at: CNT_W'(pos), count: count_dec};
        end
      end
      OP_WRITE_HEAD: begin
        plan_o = '{act: ACT_WRITE, ok: 1'b1, at: '0,
                   count: (empty ? cnt_t'(1) : count_i)};
      end
      OP_WRITE_TAIL: begin
        plan_o = '{act: ACT_WRITE, ok: 1'b1, at: (empty ? cnt_t'(0) : count_dec),
                   count: (empty ? cnt_t'(1) : count_i)};
      end
      default: begin
        plan_o.act = ACT_NONE;
      end
    endcase
  end

endmodule
